[design/ecmc_pkg.sv]
// Shared types and constants for the EWMA clock margin classifier.
// Used by the divider, datapath, controller and top level.
package ecmc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int CLK_W      = 32;
	localparam int H_W        = 15;
	localparam int N_W        = 4;
	localparam int ALPHA_W    = 17;
	localparam int DVD_W      = 36;
	localparam int DSR_W      = 5;
	localparam int DIGIT_W    = 4;
	localparam int DIGITS     = DVD_W / DIGIT_W;
	localparam int CNT_W      = 4;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 72;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
	localparam logic [CLK_W-1:0]   INIT_CLOCK_RST = 32'd4194304;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd3277;
	localparam logic signed [CLK_W-1:0] S32_MAX = 32'sh7FFF_FFFF;

	typedef enum logic [0:0] {
		REG_INITIAL_CLOCK = 1'b0,
		REG_ALPHA         = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		VERDICT_VALID      = 2'd0,
		VERDICT_IMPOSSIBLE = 2'd1,
		VERDICT_TOO_LOW    = 2'd2,
		VERDICT_TOO_HIGH   = 2'd3
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_WAIT,
		ST_MUL,
		ST_UPD
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic mul;
		logic upd;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
		logic last;
	} dp_status_t;

endpackage

[design/ewma_clock_margin_classifier.sv]
// EWMA clock margin classifier, top level.
// Requests are accepted one at a time: ready returns once an item has passed the
// start, wait, multiply and update states; wait runs three 4-bit-per-cycle dividers.
// A result becomes valid when the last request of a run is updated and
// is held in an output register; a held result stalls the next run's last request.
// Asynchronous active-low reset restores defaults.
module ewma_clock_margin_classifier import ecmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CLK_W-1:0]      cfg_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// interval[14:0], expected_half_clocks[18:15], zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// verdict[1:0], lower_margin[33:2], upper_margin[65:34], matched[66], zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata
);

	dp_cmd_t    cmd;
	dp_status_t status;

	ecmc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status, .cmd
	);

	ecmc_datapath u_dp (
		.clk, .arst_n, .cmd, .status,
		.cfg_we, .cfg_index, .cfg_data,
		.in_data(s_axis_tdata),
		.in_last(s_axis_tlast),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);

endmodule

[design/ecmc_div.sv]
// Radix-16 restoring divider for a small divisor, four quotient bits a cycle.
// Uses ecmc_pkg for widths.
module ecmc_div import ecmc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	logic [DVD_W-1:0] dvd_q, quo_q, d;
	logic [DSR_W-1:0] dsr_q, rem_q, r;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DIGIT_W-1:0] qb;
	logic [DSR_W:0]   t;

	always_comb begin
		r  = rem_q;
		d  = dvd_q;
		qb = '0;
		t  = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, d[DVD_W-1]};
			d = {d[DVD_W-2:0], 1'b0};
			if (t >= {1'b0, dsr_q}) begin
				r = DSR_W'(t - {1'b0, dsr_q});
				qb[DIGIT_W-1-i] = 1'b1;
			end else begin
				r = t[DSR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIGITS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= d;
			rem_q <= r;
			quo_q <= {quo_q[DVD_W-DIGIT_W-1:0], qb};
		end
	end

	assign quotient = quo_q;
	assign done     = !busy_q;

endmodule

[design/ecmc_datapath.sv]
// Datapath: match test, bound divisions, margins, running minima, EWMA update
// and the result register. Uses ecmc_pkg and three ecmc_div lanes.
module ecmc_datapath import ecmc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [CLK_W-1:0]      cfg_data,
	input  logic [IN_DATA_W-1:0]  in_data,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data
);

	logic [CLK_W-1:0]   init_clock_q, clk_est_q, c_q;
	logic [ALPHA_W-1:0] alpha_q, a_q;
	logic [H_W-1:0]     h_q;
	logic [N_W-1:0]     n_q;
	logic               last_q, run_start_q, mism_q, out_valid_q;
	logic signed [CLK_W-1:0] lo_min_q, up_min_q, lm_q, um_q;
	logic [48:0]        p_keep_q, p_new_q;
	logic [OUT_DATA_W-1:0] out_q;

	logic [32:0] num4;
	logic [31:0] num2;
	logic [33:0] x;
	logic [36:0] lo_lim;
	logic [37:0] hi_lim;
	logic        fail;
	logic [DVD_W-1:0] dvd_lo, dvd_up, dvd_id, q_lo, q_up, q_id;
	logic [DSR_W-1:0] dsr_lo, dsr_up, dsr_id;
	logic        dn_lo, dn_up, dn_id;
	logic [CLK_W-1:0] ideal;
	logic signed [37:0] lower_b, upper_b, lm_w, um_w;
	logic signed [CLK_W-1:0] lm_s, um_s, lo_new, up_new;
	logic [49:0] acc;
	logic [33:0] acc_sh;
	logic [1:0]  verdict;
	logic        n_zero;

	assign n_zero = (n_q == '0);
	assign num4   = {h_q, 18'd0};
	assign num2   = {h_q, 17'd0};

	// round(2h/c) == n  <=>  2nc <= 4h*2^F + c < 2(n+1)c
	assign x      = {1'b0, num4} + 34'(c_q);
	assign lo_lim = 37'(n_q) * 37'({c_q, 1'b0});
	assign hi_lim = 38'({1'b0, n_q} + 5'd1) * 38'({c_q, 1'b0});
	assign fail   = (c_q == '0) || (37'(x) < lo_lim) || (38'(x) >= hi_lim);

	assign dvd_lo = DVD_W'(num4) + DVD_W'(n_q);
	assign dsr_lo = {n_q, 1'b1};
	assign dvd_up = n_zero ? '0 : DVD_W'(num4) + DVD_W'(n_q) - DVD_W'(1);
	assign dsr_up = n_zero ? DSR_W'(1) : DSR_W'({n_q, 1'b0} - 5'd1);
	assign dvd_id = DVD_W'(num2) + DVD_W'(n_q >> 1);
	assign dsr_id = n_zero ? DSR_W'(1) : DSR_W'(n_q);

	ecmc_div u_div_lo (.clk, .arst_n, .start(cmd.start), .dividend(dvd_lo),
		.divisor(dsr_lo), .quotient(q_lo), .done(dn_lo));
	ecmc_div u_div_up (.clk, .arst_n, .start(cmd.start), .dividend(dvd_up),
		.divisor(dsr_up), .quotient(q_up), .done(dn_up));
	ecmc_div u_div_id (.clk, .arst_n, .start(cmd.start), .dividend(dvd_id),
		.divisor(dsr_id), .quotient(q_id), .done(dn_id));

	assign ideal   = n_zero ? '1 : q_id[CLK_W-1:0];
	assign lower_b = signed'(38'(q_lo));
	assign upper_b = n_zero ? -signed'(38'(num4)) : signed'(38'(q_up));
	assign lm_w    = signed'(38'(c_q)) - lower_b;
	assign um_w    = upper_b - signed'(38'(c_q));

	function automatic logic signed [CLK_W-1:0] sat32(input logic signed [37:0] v);
		if (v > 38'sh0_7FFF_FFFF) return S32_MAX;
		if (v < -38'sh0_8000_0000) return 32'sh8000_0000;
		return v[CLK_W-1:0];
	endfunction

	assign lm_s = sat32(lm_w);
	assign um_s = sat32(um_w);

	assign acc    = 50'(p_keep_q) + 50'(p_new_q) + 50'd32768;
	assign acc_sh = acc[49:16];

	assign lo_new = (lm_q < lo_min_q) ? lm_q : lo_min_q;
	assign up_new = (um_q < up_min_q) ? um_q : up_min_q;

	always_comb begin
		if (lo_new > 0 && up_new > 0)
			verdict = VERDICT_VALID;
		else if (lo_new >= 0 && up_new >= 0 && !mism_q)
			verdict = VERDICT_VALID;
		else if (lo_new <= 0 && up_new <= 0)
			verdict = VERDICT_IMPOSSIBLE;
		else if (lo_new <= 0)
			verdict = VERDICT_TOO_LOW;
		else
			verdict = VERDICT_TOO_HIGH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_clock_q <= INIT_CLOCK_RST;
			alpha_q      <= ALPHA_RST;
			run_start_q  <= 1'b1;
			mism_q       <= 1'b0;
			lo_min_q     <= S32_MAX;
			up_min_q     <= S32_MAX;
			clk_est_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INITIAL_CLOCK: init_clock_q <= cfg_data;
					REG_ALPHA:         alpha_q      <= cfg_data[ALPHA_W-1:0];
					default:           ;
				endcase
			end
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (cmd.load && run_start_q) begin
				run_start_q <= 1'b0;
				mism_q      <= 1'b0;
				lo_min_q    <= S32_MAX;
				up_min_q    <= S32_MAX;
			end
			if (cmd.start && fail) mism_q <= 1'b1;
			if (cmd.upd) begin
				if (last_q) begin
					run_start_q <= 1'b1;
					clk_est_q   <= '0;
					lo_min_q    <= S32_MAX;
					up_min_q    <= S32_MAX;
					mism_q      <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					clk_est_q <= (acc_sh[33:32] != 2'b00) ? '1 : acc_sh[CLK_W-1:0];
					lo_min_q  <= lo_new;
					up_min_q  <= up_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			h_q    <= in_data[H_W-1:0];
			n_q    <= in_data[H_W+N_W-1:H_W];
			last_q <= in_last;
			c_q    <= run_start_q ? init_clock_q : clk_est_q;
			a_q    <= (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		end
		if (cmd.mul) begin
			p_keep_q <= 49'(ALPHA_ONE - a_q) * 49'(c_q);
			p_new_q  <= 49'(a_q) * 49'(ideal);
			lm_q     <= lm_s;
			um_q     <= um_s;
		end
		if (cmd.upd && last_q)
			out_q <= {5'd0, !mism_q, up_new, lo_new, verdict};
	end

	assign status.div_done = dn_lo & dn_up & dn_id;
	assign status.out_busy = out_valid_q & !out_ready;
	assign status.last     = last_q;
	assign out_valid       = out_valid_q;
	assign out_data        = out_q;

endmodule

[design/ecmc_ctrl.sv]
// Controller state machine sequencing one item through the datapath.
// Uses ecmc_pkg for the state and command types.
module ecmc_ctrl import ecmc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (status.div_done) state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				// A finished run waits here only while the previous result is still held.
				if (!(status.last && status.out_busy)) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
